FILE: design/pic_pkg.sv
// shared types and codes for the point-in-convex-polygon block
// no dependencies; imported by the edge unit, the sequencer and the top level
package pic_pkg;

   // item command codes
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // result location codes
   localparam logic [1:0] LOC_INSIDE   = 2'd0;
   localparam logic [1:0] LOC_BOUNDARY = 2'd1;
   localparam logic [1:0] LOC_OUTSIDE  = 2'd2;

   // register file
   localparam int  CSR_ADDR_W       = 3;
   localparam logic REG_VERTEX_COUNT = 1'b0;
   localparam int  VCOUNT_W         = 5;
   localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 5'd3;
   localparam int  MIN_VERTICES     = 3;

   // side of an edge the point lies on
   typedef enum logic [1:0] {
      SIDE_ZERO = 2'd0,
      SIDE_POS  = 2'd1,
      SIDE_NEG  = 2'd2
   } side_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_ISSUE = 2'd1,
      ST_DRAIN = 2'd2
   } state_type;

   // marks one edge entering the edge pipeline
   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } edge_tag_type;

   // per-edge outcome leaving the edge pipeline
   typedef struct packed {
      logic     valid;
      logic     first;
      logic     last;
      side_type side;
      logic     on_seg;
   } edge_res_type;

endpackage

FILE: design/pic_vstore.sv
// vertex store: one write port, one read port, registered read data
// depends on nothing but its parameters
module pic_vstore #(
   parameter int DEPTH = 16,
   parameter int AW    = 4,
   parameter int DW    = 32
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/pic_edge_unit.sv
// edge test pipeline: differences and bounding box, two products, side sign
// depends on pic_pkg
module pic_edge_unit #(
   parameter int CW = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  pic_pkg::edge_tag_type  tag_in,
   input  logic signed [CW-1:0]   prev_x,
   input  logic signed [CW-1:0]   prev_y,
   input  logic signed [CW-1:0]   cur_x,
   input  logic signed [CW-1:0]   cur_y,
   input  logic signed [CW-1:0]   pt_x,
   input  logic signed [CW-1:0]   pt_y,
   output pic_pkg::edge_res_type  res_out
);
   import pic_pkg::*;

   localparam int DW1 = CW + 1;
   localparam int PW  = 2 * DW1;

   edge_tag_type           tag1_ff, tag2_ff;
   logic signed [DW1-1:0]  ex_ff, ey_ff, ox_ff, oy_ff;
   logic signed [DW1-1:0]  ex_in, ey_in, ox_in, oy_in;
   logic                   inbox_in, inbox1_ff, inbox2_ff;
   logic signed [CW-1:0]   lo_x, hi_x, lo_y, hi_y;
   logic signed [PW-1:0]   p1_ff, p2_ff, p1_in, p2_in;
   edge_res_type           res_ff, res_in;

   // stage 1: edge vector, point offset, bounding box check
   always_comb begin
      ex_in = DW1'(cur_x) - DW1'(prev_x);
      ey_in = DW1'(cur_y) - DW1'(prev_y);
      ox_in = DW1'(pt_x) - DW1'(prev_x);
      oy_in = DW1'(pt_y) - DW1'(prev_y);
      lo_x  = (prev_x < cur_x) ? prev_x : cur_x;
      hi_x  = (prev_x < cur_x) ? cur_x : prev_x;
      lo_y  = (prev_y < cur_y) ? prev_y : cur_y;
      hi_y  = (prev_y < cur_y) ? cur_y : prev_y;
      inbox_in = (pt_x >= lo_x) && (pt_x <= hi_x) && (pt_y >= lo_y) && (pt_y <= hi_y);
   end

   always_ff @(posedge clock) begin
      ex_ff     <= ex_in;
      ey_ff     <= ey_in;
      ox_ff     <= ox_in;
      oy_ff     <= oy_in;
      inbox1_ff <= inbox_in;
   end

   // stage 2: the two cross product terms
   always_comb begin
      p1_in = PW'(ex_ff) * PW'(oy_ff);
      p2_in = PW'(ey_ff) * PW'(ox_ff);
   end

   always_ff @(posedge clock) begin
      p1_ff     <= p1_in;
      p2_ff     <= p2_in;
      inbox2_ff <= inbox1_ff;
   end

   // stage 3: sign of the difference and on-segment flag
   always_comb begin
      res_in.valid = tag2_ff.valid;
      res_in.first = tag2_ff.first;
      res_in.last  = tag2_ff.last;
      if (p1_ff > p2_ff) begin
         res_in.side = SIDE_POS;
      end else if (p1_ff < p2_ff) begin
         res_in.side = SIDE_NEG;
      end else begin
         res_in.side = SIDE_ZERO;
      end
      res_in.on_seg = (p1_ff == p2_ff) && inbox2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
         res_ff  <= '0;
      end else begin
         tag1_ff <= tag_in;
         tag2_ff <= tag1_ff;
         res_ff  <= res_in;
      end
   end

   assign res_out = res_ff;

   // a valid edge result only follows a valid input tag carried through tag1, tag2 and the result register
   a_res_follows_tag: assert property (@(posedge clock) disable iff (reset)
      res_out.valid |-> $past(tag_in.valid, 3))
      else $error("edge result without matching tag");

endmodule

FILE: design/pic_seq.sv
// query sequencer: walks the vertex store, feeds edges, folds edge results
// depends on pic_pkg
module pic_seq #(
   parameter int CW    = 16,
   parameter int AW    = 4,
   parameter int CNT_W = 5
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   query_go,
   input  logic signed [CW-1:0]   query_x,
   input  logic signed [CW-1:0]   query_y,
   input  logic [CNT_W-1:0]       n_vertices,
   output logic                   rd_en,
   output logic [AW-1:0]          rd_addr,
   input  logic [2*CW-1:0]        rd_data,
   output pic_pkg::edge_tag_type  tag_out,
   output logic signed [CW-1:0]   prev_x,
   output logic signed [CW-1:0]   prev_y,
   output logic signed [CW-1:0]   cur_x,
   output logic signed [CW-1:0]   cur_y,
   output logic signed [CW-1:0]   pt_x,
   output logic signed [CW-1:0]   pt_y,
   input  pic_pkg::edge_res_type  res_in,
   output logic                   busy,
   output logic                   rsp_valid,
   output logic [1:0]             rsp_location
);
   import pic_pkg::*;

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      step_ff, step_in, n_ff;
   logic signed [CW-1:0]  px_ff, py_ff;
   logic                  iss_v_ff, iss_zero_ff, iss_first_ff, iss_close_ff;
   logic signed [CW-1:0]  v0x_ff, v0y_ff, prvx_ff, prvy_ff;
   logic signed [CW-1:0]  vtx_x, vtx_y;
   side_type              first_side_ff;
   logic                  boundary_ff, mismatch_ff, boundary_in, mismatch_in;
   logic                  rsp_valid_ff;
   logic [1:0]            loc_ff;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // next state and read issue
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      rd_en    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (query_go) begin
               state_in = ST_ISSUE;
               step_in  = '0;
            end
         end
         ST_ISSUE: begin
            rd_en   = (step_ff < n_ff);
            step_in = step_ff + 1'b1;
            if (step_ff == n_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (res_in.valid && res_in.last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rd_addr = step_ff[AW-1:0];
   assign busy    = (state_ff != ST_IDLE);

   // query point and vertex count held for the whole walk
   always_ff @(posedge clock) begin
      if (query_go && (state_ff == ST_IDLE)) begin
         px_ff <= query_x;
         py_ff <= query_y;
         n_ff  <= n_vertices;
      end
   end

   // issue marker, lines up with the read data
   always_ff @(posedge clock) begin
      if (reset) begin
         iss_v_ff <= 1'b0;
      end else begin
         iss_v_ff <= (state_ff == ST_ISSUE);
      end
   end

   always_ff @(posedge clock) begin
      iss_zero_ff  <= (step_ff == '0);
      iss_first_ff <= (step_ff == CNT_W'(1));
      iss_close_ff <= (step_ff == n_ff);
   end

   // closing edge returns to vertex 0
   always_comb begin
      vtx_x = iss_close_ff ? v0x_ff : rd_data[CW-1:0];
      vtx_y = iss_close_ff ? v0y_ff : rd_data[2*CW-1:CW];
   end

   always_ff @(posedge clock) begin
      if (iss_v_ff) begin
         prvx_ff <= vtx_x;
         prvy_ff <= vtx_y;
         if (iss_zero_ff) begin
            v0x_ff <= vtx_x;
            v0y_ff <= vtx_y;
         end
      end
   end

   // edge from previous vertex to this one
   assign tag_out.valid = iss_v_ff && !iss_zero_ff;
   assign tag_out.first = iss_first_ff;
   assign tag_out.last  = iss_close_ff;
   assign prev_x = prvx_ff;
   assign prev_y = prvy_ff;
   assign cur_x  = vtx_x;
   assign cur_y  = vtx_y;
   assign pt_x   = px_ff;
   assign pt_y   = py_ff;

   // fold edge results
   always_comb begin
      if (res_in.first) begin
         boundary_in = res_in.on_seg;
         mismatch_in = 1'b0;
      end else begin
         boundary_in = boundary_ff || res_in.on_seg;
         mismatch_in = mismatch_ff || (res_in.side != first_side_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (res_in.valid) begin
         boundary_ff <= boundary_in;
         mismatch_ff <= mismatch_in;
         if (res_in.first) begin
            first_side_ff <= res_in.side;
         end
      end
   end

   // result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= res_in.valid && res_in.last;
      end
   end

   always_ff @(posedge clock) begin
      if (res_in.valid && res_in.last) begin
         if (boundary_in) begin
            loc_ff <= LOC_BOUNDARY;
         end else if (mismatch_in) begin
            loc_ff <= LOC_OUTSIDE;
         end else begin
            loc_ff <= LOC_INSIDE;
         end
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_location = loc_ff;

   // edges only come back while a query is running
   a_res_while_busy: assert property (@(posedge clock) disable iff (reset)
      res_in.valid |-> (state_ff != ST_IDLE))
      else $error("edge result while idle");

   // each result comes from the closing edge of the previous cycle
   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(res_in.valid && res_in.last))
      else $error("result without closing edge");

   // the walk never passes the closing step
   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ISSUE) |-> (step_ff <= n_ff))
      else $error("step counter past vertex count");

endmodule

FILE: design/point_in_convex_polygon.sv
// top level of the point-in-convex-polygon block: register port, store, walk
// depends on pic_pkg, pic_vstore, pic_edge_unit, pic_seq
//
//   channel   ports                         handshake
//   input     req_cmd/req_vertex_index/     start high, busy low
//             req_coord_x/req_coord_y
//   result    rsp_location                  rsp_valid, one cycle, no backpressure
//   config    psel/penable/pwrite/paddr/    apb, pready always high
//             pwdata/prdata
//
// a load item does not raise busy, so a new item can follow on the next edge
// a query over n vertices keeps busy high through the walk (one store read per vertex,
// then the closing edge) and while the last edge passes the read data register and the edge stages
// the result strobe and the drop of busy come on the same cycle
// reset clears control state and sets the vertex count to 3; the store is not cleared
module point_in_convex_polygon #(
   parameter int MAX_VERTICES = 16,
   parameter int COORD_WIDTH  = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_cmd,
   input  logic [3:0]                      req_vertex_index,
   input  logic signed [15:0]              req_coord_x,
   input  logic signed [15:0]              req_coord_y,
   output logic                            rsp_valid,
   output logic [1:0]                      rsp_location,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [pic_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);
   import pic_pkg::*;

   localparam int AW    = $clog2(MAX_VERTICES);
   localparam int CNT_W = $clog2(MAX_VERTICES + 1);
   localparam int CW    = COORD_WIDTH;

   logic [VCOUNT_W-1:0]   vcount_ff;
   logic                  reg_sel;
   logic [CNT_W-1:0]      n_clamped;
   logic signed [CW-1:0]  in_x, in_y;
   logic                  accept, wr_en, query_go;
   logic                  rd_en;
   logic [AW-1:0]         rd_addr;
   logic [2*CW-1:0]       rd_data;
   edge_tag_type          tag;
   edge_res_type          res;
   logic signed [CW-1:0]  prev_x, prev_y, cur_x, cur_y, pt_x, pt_y;

   // register port
   assign reg_sel = (paddr[2] == REG_VERTEX_COUNT);
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= VCOUNT_RESET;
      end else if (psel && penable && pwrite && reg_sel) begin
         vcount_ff <= pwdata[VCOUNT_W-1:0];
      end
   end

   assign prdata = reg_sel ? 32'(vcount_ff) : 32'd0;

   // vertex count held to the supported range
   always_comb begin
      if (int'(vcount_ff) < MIN_VERTICES) begin
         n_clamped = CNT_W'(MIN_VERTICES);
      end else if (int'(vcount_ff) > MAX_VERTICES) begin
         n_clamped = CNT_W'(MAX_VERTICES);
      end else begin
         n_clamped = CNT_W'(vcount_ff);
      end
   end

   // port bits taken at the stored width, signed from its top bit
   assign in_x = CW'(unsigned'(req_coord_x));
   assign in_y = CW'(unsigned'(req_coord_y));

   // item decode
   assign accept   = start && !busy;
   assign wr_en    = accept && (req_cmd == CMD_LOAD)
                     && (int'(req_vertex_index) < MAX_VERTICES);
   assign query_go = accept && (req_cmd == CMD_QUERY);

   pic_vstore #(
      .DEPTH (MAX_VERTICES),
      .AW    (AW),
      .DW    (2 * CW)
   ) u_vstore (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(req_vertex_index)),
      .wr_data ({in_y, in_x}),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   pic_seq #(
      .CW    (CW),
      .AW    (AW),
      .CNT_W (CNT_W)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .query_go     (query_go),
      .query_x      (in_x),
      .query_y      (in_y),
      .n_vertices   (n_clamped),
      .rd_en        (rd_en),
      .rd_addr      (rd_addr),
      .rd_data      (rd_data),
      .tag_out      (tag),
      .prev_x       (prev_x),
      .prev_y       (prev_y),
      .cur_x        (cur_x),
      .cur_y        (cur_y),
      .pt_x         (pt_x),
      .pt_y         (pt_y),
      .res_in       (res),
      .busy         (busy),
      .rsp_valid    (rsp_valid),
      .rsp_location (rsp_location)
   );

   pic_edge_unit #(
      .CW (CW)
   ) u_edge (
      .clock   (clock),
      .reset   (reset),
      .tag_in  (tag),
      .prev_x  (prev_x),
      .prev_y  (prev_y),
      .cur_x   (cur_x),
      .cur_y   (cur_y),
      .pt_x    (pt_x),
      .pt_y    (pt_y),
      .res_out (res)
   );

   // no store write while a query walks the store
   a_no_write_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !wr_en)
      else $error("store write during query");

   // a query always raises busy on the next cycle
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      query_go |=> busy)
      else $error("query accepted without busy");

   // no result while an accepted query has just started
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      query_go |=> !rsp_valid)
      else $error("result right after query accept");

endmodule
